@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

@@ rtl/core/isae_pkg.sv @@
`timescale 1ns / 1ps
package isae_pkg;
    localparam int DEPTH_DEF      = 64;
    localparam int VALUE_BITS_DEF = 32;

    typedef enum logic [3:0] {
        OP_GET = 4'd0, OP_SET = 4'd1, OP_INSERT = 4'd2, OP_APPEND = 4'd3,
        OP_REMOVE = 4'd4, OP_SINSERT = 4'd5, OP_BSEARCH = 4'd6, OP_FIND = 4'd7,
        OP_COUNT = 4'd8, OP_REMALL = 4'd9, OP_REVERSE = 4'd10, OP_SORT = 4'd11,
        OP_CLEAR = 4'd12
    } op_t;

    localparam logic [1:0] ST_OK = 2'd0, ST_RANGE = 2'd1, ST_FULL = 2'd2,
                           ST_NOTFOUND = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_RD, S_WAIT, S_USE, S_WR, S_DONE, S_OUT
    } state_t;

    // Datapath command codes
    typedef enum logic [3:0] {
        C_NONE, C_LOAD, C_DECIDE, C_SCAN_RD, C_SCAN_USE, C_FINISH
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
    } ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sts_t;
endpackage

@@ rtl/core/isae_datapath.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Datapath: memory, counters and per-op micro-sequencer. Every op is a
// sequence of single-port memory read (registered) and write steps.
module isae_datapath import isae_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_signed,
    input  ctl_t        ctl,
    input  logic [3:0]  in_op,
    input  logic [5:0]  in_pos,
    input  logic [31:0] in_val,
    output sts_t        sts,
    output logic [31:0] r_value,
    output logic [5:0]  r_index,
    output logic [6:0]  r_count,
    output logic [6:0]  r_fill,
    output logic [1:0]  r_status
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 6) ? CW : 6;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [4:0] {
        P_IDLE, P_RDW, P_RDU,
        P_SH_UP_RD, P_SH_UP_U, P_SH_DN_RD, P_SH_DN_U,
        P_BS_RD, P_BS_U, P_BS_FIN_RD, P_BS_FIN_U,
        P_LIN_RD, P_LIN_U,
        P_RV_RDA, P_RV_RDB, P_RV_WA,
        P_SO_RDT, P_SO_RDJ, P_SO_U,
        P_GET_U, P_END
    } ph_t;

    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic [VALUE_BITS-1:0] rd_reg;
    logic                  we;
    logic [AW-1:0]         wa, ra;
    logic [VALUE_BITS-1:0] wd;
    logic                  re;

    ph_t ph_reg, ph_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, n_reg, n_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [VALUE_BITS-1:0] t_reg, t_next, v_reg;
    logic [3:0] op_reg;
    logic [5:0] pos_reg;
    logic [31:0] ov_reg, ov_next;
    logic [5:0]  oi_reg, oi_next;
    logic [6:0]  oc_reg, oc_next;
    logic [1:0]  os_reg, os_next;
    logic        done_reg, done_next;

    // Memory: one write and one registered read each cycle
    always_ff @(posedge aclk) begin
        if (we) mem[wa] <= wd;
        if (re) rd_reg <= mem[ra];
    end

    // Ordered compare of two values
    function automatic logic [1:0] ord(input logic [VALUE_BITS-1:0] a,
                                       input logic [VALUE_BITS-1:0] b,
                                       input logic sg);
        logic [VALUE_BITS-1:0] aa, bb;
        begin
            aa = a; bb = b;
            if (sg) begin
                aa[VALUE_BITS-1] = ~a[VALUE_BITS-1];
                bb[VALUE_BITS-1] = ~b[VALUE_BITS-1];
            end
            if (aa < bb) ord = 2'b10;
            else if (aa > bb) ord = 2'b01;
            else ord = 2'b00;
        end
    endfunction

    logic [1:0] c_rd;
    logic [CW-1:0] pos_w;
    logic pos_bad;
    assign c_rd    = ord(v_reg, rd_reg, cfg_signed);
    assign pos_w   = CW'(pos_reg);
    // Compare the full requested index against the count
    assign pos_bad = (PW'(pos_reg) >= PW'(cnt_reg));

    always_comb begin
        ph_next = ph_reg; cnt_next = cnt_reg; i_next = i_reg; j_next = j_reg;
        n_next = n_reg; lo_next = lo_reg; hi_next = hi_reg; mid_next = mid_reg;
        t_next = t_reg; ov_next = ov_reg; oi_next = oi_reg; oc_next = oc_reg;
        os_next = os_reg; done_next = 1'b0;
        we = 1'b0; wa = '0; wd = v_reg; re = 1'b0; ra = '0;
        case (ph_reg)
            P_IDLE: begin
                if (ctl.cmd == C_DECIDE) begin
                    ov_next = '0; oi_next = '0; oc_next = '0; os_next = ST_OK;
                    ph_next = P_END;
                    case (op_reg)
                        OP_GET: if (pos_bad) os_next = ST_RANGE;
                                else begin re = 1'b1; ra = AW'(pos_reg); ph_next = P_GET_U; end
                        OP_SET: if (pos_bad) os_next = ST_RANGE;
                                else begin we = 1'b1; wa = AW'(pos_reg); end
                        OP_INSERT:
                            if (pos_bad) os_next = ST_RANGE;
                            else if (cnt_reg >= DEPTH_C) os_next = ST_FULL;
                            else begin mid_next = pos_w; i_next = cnt_reg;
                                ph_next = P_SH_UP_RD; end
                        OP_APPEND:
                            if (cnt_reg >= DEPTH_C) os_next = ST_FULL;
                            else begin we = 1'b1; wa = cnt_reg[AW-1:0];
                                cnt_next = cnt_reg + 1'b1; end
                        OP_REMOVE:
                            if (pos_bad) os_next = ST_RANGE;
                            else begin re = 1'b1; ra = AW'(pos_reg); i_next = pos_w;
                                ph_next = P_SH_DN_RD; t_next = '0; end
                        OP_SINSERT, OP_BSEARCH: begin
                            if (op_reg == OP_BSEARCH) os_next = ST_NOTFOUND;
                            if (op_reg == OP_SINSERT && cnt_reg >= DEPTH_C)
                                os_next = ST_FULL;
                            else if (cnt_reg == '0) begin
                                if (op_reg == OP_SINSERT) begin
                                    we = 1'b1; wa = '0; cnt_next = CW'(1);
                                end
                            end else begin
                                lo_next = '0; hi_next = cnt_reg - 1'b1;
                                ph_next = P_BS_RD;
                            end
                        end
                        OP_FIND, OP_COUNT, OP_REMALL: begin
                            if (op_reg == OP_FIND) os_next = ST_NOTFOUND;
                            i_next = '0; n_next = '0; ph_next = P_LIN_RD;
                        end
                        OP_REVERSE: begin i_next = '0; j_next = cnt_reg - 1'b1;
                            ph_next = P_RV_RDA; end
                        OP_SORT: begin i_next = CW'(1); ph_next = P_SO_RDT; end
                        OP_CLEAR: cnt_next = '0;
                        default: os_next = ST_RANGE;
                    endcase
                end
            end
            P_GET_U: begin ph_next = P_RDU; end
            P_RDU: begin ov_next = 32'(rd_reg); ph_next = P_END; end
            // Shift up from the top, then place the value at mid
            P_SH_UP_RD: begin
                if (i_reg == mid_reg) begin
                    we = 1'b1; wa = mid_reg[AW-1:0]; wd = v_reg;
                    cnt_next = cnt_reg + 1'b1; oi_next = 6'(mid_reg);
                    if (op_reg != OP_SINSERT) oi_next = '0;
                    ph_next = P_END;
                end else begin
                    re = 1'b1; ra = AW'(i_reg - 1'b1); ph_next = P_SH_UP_U;
                end
            end
            P_SH_UP_U: begin
                we = 1'b1; wa = i_reg[AW-1:0]; wd = rd_reg;
                i_next = i_reg - 1'b1; ph_next = P_SH_UP_RD;
            end
            // Shift down from pos; first read returns the removed value
            P_SH_DN_RD: begin
                if (t_reg == '0) begin ov_next = 32'(rd_reg); t_next = '1; end
                if (i_reg + 1'b1 >= cnt_reg) begin
                    cnt_next = cnt_reg - 1'b1; ph_next = P_END;
                end else begin
                    re = 1'b1; ra = AW'(i_reg + 1'b1); ph_next = P_SH_DN_U;
                end
            end
            P_SH_DN_U: begin ph_next = P_RDW; end
            P_RDW: begin
                we = 1'b1; wa = i_reg[AW-1:0]; wd = rd_reg;
                i_next = i_reg + 1'b1; ph_next = P_SH_DN_RD;
            end
            // Halving search
            P_BS_RD: begin
                if (lo_reg < hi_reg) begin
                    mid_next = lo_reg + ((hi_reg - lo_reg) >> 1);
                    re = 1'b1; ra = AW'(lo_reg + ((hi_reg - lo_reg) >> 1));
                    ph_next = P_BS_U;
                end else if (op_reg == OP_SINSERT || lo_reg == hi_reg) begin
                    re = 1'b1; ra = lo_reg[AW-1:0]; ph_next = P_BS_FIN_RD;
                end else ph_next = P_END;
            end
            P_BS_U: begin
                if (c_rd == 2'b00) begin
                    if (op_reg == OP_SINSERT) begin
                        i_next = cnt_reg; ph_next = P_SH_UP_RD;
                    end else begin
                        oi_next = 6'(mid_reg); os_next = ST_OK; ph_next = P_END;
                    end
                end else if (c_rd == 2'b10) begin
                    if (mid_reg == '0) begin
                        if (op_reg == OP_SINSERT) begin
                            hi_next = mid_reg; ph_next = P_BS_RD;
                        end else ph_next = P_END;
                    end else begin hi_next = mid_reg - 1'b1; ph_next = P_BS_RD; end
                end else begin lo_next = mid_reg + 1'b1; ph_next = P_BS_RD; end
            end
            P_BS_FIN_RD: ph_next = P_BS_FIN_U;
            P_BS_FIN_U: begin
                if (op_reg == OP_SINSERT) begin
                    mid_next = (c_rd == 2'b01) ? lo_reg + 1'b1 : lo_reg;
                    i_next = cnt_reg; ph_next = P_SH_UP_RD;
                end else begin
                    if (c_rd == 2'b00) begin oi_next = 6'(lo_reg); os_next = ST_OK; end
                    ph_next = P_END;
                end
            end
            // Linear scan: find, count, remove all (compaction via n)
            P_LIN_RD: begin
                if (i_reg >= cnt_reg) begin
                    if (op_reg == OP_REMALL) cnt_next = n_reg;
                    ph_next = P_END;
                end else begin re = 1'b1; ra = i_reg[AW-1:0]; ph_next = P_LIN_U; end
            end
            P_LIN_U: ph_next = P_RDW;
            P_RV_RDA: begin
                if (i_reg >= j_reg || cnt_reg == '0) ph_next = P_END;
                else begin re = 1'b1; ra = i_reg[AW-1:0]; ph_next = P_RV_RDB; end
            end
            P_RV_RDB: begin re = 1'b1; ra = j_reg[AW-1:0]; t_next = rd_reg;
                ph_next = P_RV_WA; end
            P_RV_WA: begin
                we = 1'b1; wa = i_reg[AW-1:0]; wd = rd_reg;
                ph_next = P_SO_U;
            end
            // Insertion sort: t = cells[i]; j walks down
            P_SO_RDT: begin
                if (i_reg >= cnt_reg) ph_next = P_END;
                else begin re = 1'b1; ra = i_reg[AW-1:0]; j_next = i_reg;
                    ph_next = P_SO_RDJ; end
            end
            P_SO_RDJ: begin
                if (j_reg == i_reg) t_next = rd_reg;
                if (j_reg == '0) begin
                    we = 1'b1; wa = '0; wd = (j_reg == i_reg) ? rd_reg : t_reg;
                    i_next = i_reg + 1'b1; ph_next = P_SO_RDT;
                end else begin
                    re = 1'b1; ra = AW'(j_reg - 1'b1); ph_next = P_SO_U;
                end
            end
            P_SO_U: begin
                if (op_reg == OP_REVERSE) begin
                    we = 1'b1; wa = j_reg[AW-1:0]; wd = t_reg;
                    i_next = i_reg + 1'b1; j_next = j_reg - 1'b1; ph_next = P_RV_RDA;
                end else if (ord(rd_reg, t_reg, cfg_signed) == 2'b01) begin
                    we = 1'b1; wa = j_reg[AW-1:0]; wd = rd_reg;
                    j_next = j_reg - 1'b1;
                    ph_next = P_SO_RDJ;
                end else begin
                    we = 1'b1; wa = j_reg[AW-1:0]; wd = t_reg;
                    i_next = i_reg + 1'b1; ph_next = P_SO_RDT;
                end
            end
            P_END: begin done_next = 1'b1; ph_next = P_IDLE; end
            default: ph_next = P_IDLE;
        endcase
        // Scan write-back shares P_RDW with remove
        if (ph_reg == P_RDW && (op_reg == OP_FIND || op_reg == OP_COUNT ||
                                op_reg == OP_REMALL)) begin
            we = 1'b0; ph_next = P_LIN_RD; i_next = i_reg + 1'b1;
            if (rd_reg == v_reg) begin
                oc_next = oc_reg + 1'b1;
                if (op_reg == OP_FIND) begin
                    oi_next = 6'(i_reg); os_next = ST_OK; ph_next = P_END; oc_next = '0;
                end
            end else if (op_reg == OP_REMALL) begin
                we = 1'b1; wa = n_reg[AW-1:0]; wd = rd_reg; n_next = n_reg + 1'b1;
            end
            if (op_reg != OP_COUNT && op_reg != OP_REMALL) oc_next = '0;
        end
        // Sort: j reaches 0 after a shift; place t at 0 via SO_RDJ (j==0 path)
        if (ph_reg == P_SO_RDJ && j_reg != i_reg && j_reg == '0) wd = t_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= P_IDLE; cnt_reg <= '0; done_reg <= 1'b0;
        end else begin
            ph_reg <= ph_next; cnt_reg <= cnt_next; done_reg <= done_next;
        end
        if (ctl.cmd == C_LOAD) begin
            op_reg <= in_op; pos_reg <= in_pos;
            v_reg <= VALUE_BITS'(in_val);
        end
        i_reg <= i_next; j_reg <= j_next; n_reg <= n_next; lo_reg <= lo_next;
        hi_reg <= hi_next; mid_reg <= mid_next; t_reg <= t_next;
        ov_reg <= ov_next; oi_reg <= oi_next; oc_reg <= oc_next; os_reg <= os_next;
    end

    assign sts.busy = (ph_reg != P_IDLE);
    assign sts.done = done_reg;
    assign r_value  = ov_reg;
    assign r_index  = oi_reg;
    assign r_count  = oc_reg;
    assign r_fill   = 7'(cnt_reg);
    assign r_status = os_reg;

    `ASSERT_NEVER(a_cnt_max, aclk, aresetn, cnt_reg > DEPTH_C, "count beyond depth")
    `ASSERT_CLK(a_done_end, aclk, aresetn, done_reg |-> $past(ph_reg) == P_END,
                "done without end phase")
    `ASSERT_CLK(a_we_range, aclk, aresetn, we |-> CW'(wa) < DEPTH_C, "write past depth")
endmodule

@@ rtl/core/isae_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Controller: accept a beat, start the datapath, present the result beat.
module isae_ctrl import isae_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output ctl_t ctl
);
    state_t st_reg, st_next;

    // Next state
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:   if (s_valid) st_next = S_DECIDE;
            S_DECIDE: st_next = S_WAIT;
            S_WAIT:   if (sts.done) st_next = S_OUT;
            S_OUT:    if (m_ready) st_next = S_IDLE;
            default:  st_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        ctl.cmd = C_NONE;
        s_ready = 1'b0; m_valid = 1'b0;
        case (st_reg)
            S_IDLE:   begin s_ready = 1'b1; if (s_valid) ctl.cmd = C_LOAD; end
            S_DECIDE: ctl.cmd = C_DECIDE;
            S_OUT:    m_valid = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= S_IDLE;
        else st_reg <= st_next;
    end

    `ASSERT_CLK(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid,
                "result beat dropped")
    `ASSERT_NEVER(a_both, aclk, aresetn, s_ready && m_valid, "accept while presenting")
    `ASSERT_CLK(a_idle_dp, aclk, aresetn, s_ready |-> !sts.busy, "datapath busy when idle")
endmodule

@@ rtl/core/indexed_sorted_array_engine_core.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Ports
// s_        in   s_valid s_ready s_operation s_position s_value_in
// m_        out  m_valid m_ready m_value_out m_found_index m_match_count
//                m_fill_level m_status
// cfg       in   cfg_we cfg_wdata
// One request at a time through a single-port cell memory. Insert and remove
// shift the entries one at a time, search halves the range at each step,
// scans walk the entries in order, and sort is an insertion sort.
// Reset (aresetn low, synchronous) empties the array; cells are not cleared.
// A stalled result beat holds the block; no new beat is taken until it goes.
module indexed_sorted_array_engine_core import isae_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_operation,
    input  logic [5:0]  s_position,
    input  logic [31:0] s_value_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value_out,
    output logic [5:0]  m_found_index,
    output logic [6:0]  m_match_count,
    output logic [6:0]  m_fill_level,
    output logic [1:0]  m_status
);
    logic sgn_reg;
    ctl_t ctl;
    sts_t sts;

    // Hold the compare mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) sgn_reg <= 1'b0;
        else if (cfg_we) sgn_reg <= cfg_wdata;
    end

    isae_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .ctl(ctl)
    );

    isae_datapath #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_signed(sgn_reg), .ctl(ctl),
        .in_op(s_operation), .in_pos(s_position), .in_val(s_value_in), .sts(sts),
        .r_value(m_value_out), .r_index(m_found_index), .r_count(m_match_count),
        .r_fill(m_fill_level), .r_status(m_status)
    );
endmodule
